[rtl/wpb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_pkg
// Shared widths and the front-to-back queue word of the peak binner.
// ----------------------------------------------------------------------------
package wpb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PEAK_W   = 16;
	localparam int FRAME_W  = 24;
	localparam int IDX_W    = 9;

	localparam logic [FRAME_W-1:0] TOTAL_RESET = FRAME_W'(1);

	typedef struct packed {
		logic [PEAK_W-1:0]  peak;
		logic [FRAME_W-1:0] frame;
		logic               last;
	} wpb_entry_t;

endpackage

[rtl/wpb_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb channels
// Valid/ready channels for frames, results and the configuration word.
// ----------------------------------------------------------------------------
interface wpb_frame_if
	import wpb_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;

	modport source(output valid, left_sample, right_sample, input ready);
	modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface wpb_result_if
	import wpb_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  bin_index;
	logic [PEAK_W-1:0] peak_level;
	logic              clip_done;

	modport source(output valid, bin_index, peak_level, clip_done, input ready);
	modport sink(input valid, bin_index, peak_level, clip_done, output ready);
endinterface

interface wpb_cfg_if
	import wpb_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

[rtl/wpb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_queue
// Two-entry queue between the front and back halves.
// ----------------------------------------------------------------------------
module wpb_queue
	import wpb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wpb_entry_t push_word,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output wpb_entry_t pop_word
);

	wpb_entry_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/wpb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_front
// Takes frames, drops those past the clip end, numbers the rest and
// queues their peak magnitude.
// ----------------------------------------------------------------------------
module wpb_front
	import wpb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic [FRAME_W-1:0]         total,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       q_full,
	output logic                       push,
	output wpb_entry_t                 push_word
);

	logic [FRAME_W-1:0] fc_q;
	logic [FRAME_W:0]   fc_next;
	logic [PEAK_W-1:0]  mag_l;
	logic [PEAK_W-1:0]  mag_r;
	logic               active;

	function automatic logic [PEAK_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] u;
		u = s;
		return u[SAMPLE_W-1] ? PEAK_W'(~u + SAMPLE_W'(1)) : PEAK_W'(u);
	endfunction

	assign in_ready = !q_full;
	assign active   = (fc_q < total);
	assign push     = in_valid && in_ready && active;
	assign fc_next  = {1'b0, fc_q} + (FRAME_W+1)'(1);
	assign mag_l    = magnitude(left_sample);
	assign mag_r    = magnitude(right_sample);

	always_comb begin
		push_word.peak  = (mag_l > mag_r) ? mag_l : mag_r;
		push_word.frame = fc_q;
		push_word.last  = (fc_next == {1'b0, total});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (clear) begin
			fc_q <= '0;
		end else if (push) begin
			fc_q <= fc_next[FRAME_W-1:0];
		end
	end

endmodule

[rtl/wpb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_back
// Serial bin divider, bin tracking and the result register.
// ----------------------------------------------------------------------------
module wpb_back
	import wpb_pkg::*;
#(
	parameter int BIN_COUNT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic [FRAME_W-1:0] total,
	input  logic               q_not_empty,
	input  wpb_entry_t         q_word,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   bin_index,
	output logic [PEAK_W-1:0]  peak_level,
	output logic               clip_done
);

	localparam int QW = $clog2(BIN_COUNT);
	localparam int KW = (QW > 1) ? $clog2(QW) : 1;
	localparam int NW = FRAME_W + QW;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     rem_q;
	logic [QW-1:0]     quo_q;
	logic [KW-1:0]     k_q;
	logic [PEAK_W-1:0] mag_q;
	logic              last_q;
	logic [QW-1:0]     open_q;
	logic [PEAK_W-1:0] max_q;
	logic              has_q;
	logic              ov_q;
	logic [IDX_W-1:0]  obin_q;
	logic [PEAK_W-1:0] opeak_q;
	logic              odone_q;

	logic [NW-1:0]       dvs;
	logic                ge;
	logic                slot_free;
	logic                need_close;
	logic                ov_set;
	logic [PEAK_W-1:0]   new_max;
	logic [IDX_W+QW-1:0] open_ext;

	assign dvs        = NW'(total) << k_q;
	assign ge         = (rem_q >= dvs);
	assign slot_free  = !ov_q || out_ready;
	assign need_close = has_q && (quo_q != open_q);
	assign ov_set     = !clear && slot_free
		&& (((state_q == ST_UPD) && need_close) || (state_q == ST_FIN));
	assign new_max    = need_close ? mag_q : ((mag_q > max_q) ? mag_q : max_q);
	assign open_ext   = {{IDX_W{1'b0}}, open_q};
	assign q_pop      = (state_q == ST_IDLE) && q_not_empty;

	assign out_valid  = ov_q;
	assign bin_index  = obin_q;
	assign peak_level = opeak_q;
	assign clip_done  = odone_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					rem_q  <= NW'(q_word.frame) * NW'(BIN_COUNT);
					quo_q  <= '0;
					k_q    <= KW'(QW - 1);
					mag_q  <= q_word.peak;
					last_q <= q_word.last;
				end
			end
			ST_DIV: begin
				if (ge) begin
					rem_q      <= rem_q - dvs;
					quo_q[k_q] <= 1'b1;
				end
				if (k_q != '0) begin
					k_q <= k_q - KW'(1);
				end
			end
			ST_UPD: begin
				if (slot_free && need_close) begin
					obin_q  <= open_ext[IDX_W-1:0];
					opeak_q <= max_q;
					odone_q <= 1'b0;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					obin_q  <= open_ext[IDX_W-1:0];
					opeak_q <= max_q;
					odone_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q  <= '0;
			max_q   <= '0;
			has_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_set) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (clear) begin
				state_q <= ST_IDLE;
				open_q  <= '0;
				max_q   <= '0;
				has_q   <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (q_not_empty) begin
							state_q <= ST_DIV;
						end
					end
					ST_DIV: begin
						if (k_q == '0) begin
							state_q <= ST_UPD;
						end
					end
					ST_UPD: begin
						if (slot_free || !need_close) begin
							open_q  <= quo_q;
							max_q   <= new_max;
							has_q   <= 1'b1;
							state_q <= last_q ? ST_FIN : ST_IDLE;
						end
					end
					ST_FIN: begin
						if (slot_free) begin
							has_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

[rtl/waveform_peak_binner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_peak_binner_top
// Stereo clip to peak-bin overview: front numbers frames, back divides
// frame * BIN_COUNT by total_frames and closes bins.
// The one-bit-per-cycle bin divider in the back half takes a new frame word
//   from the queue only once it is through with the last one.
// A frame word that closes a bin gives a bin-close word; the last frame of
//   a clip then also gives the clip-end word.
// Reset: clip state cleared, total_frames = 1, no clearing pass.
// ----------------------------------------------------------------------------
module waveform_peak_binner_top
	import wpb_pkg::*;
#(
	parameter int BIN_COUNT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	wpb_cfg_if.sink     cfg,
	wpb_frame_if.sink   frame,
	wpb_result_if.source result
);

	logic [FRAME_W-1:0] total_q;
	logic               clip_clear;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_not_empty;
	wpb_entry_t         q_push_word;
	wpb_entry_t         q_pop_word;

	assign cfg.ready  = 1'b1;
	assign clip_clear = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (clip_clear) begin
			total_q <= cfg.data;
		end
	end

	wpb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (clip_clear),
		.total        (total_q),
		.in_valid     (frame.valid),
		.in_ready     (frame.ready),
		.left_sample  (frame.left_sample),
		.right_sample (frame.right_sample),
		.q_full       (q_full),
		.push         (q_push),
		.push_word    (q_push_word)
	);

	wpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_push_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_word  (q_pop_word)
	);

	wpb_back #(
		.BIN_COUNT (BIN_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clip_clear),
		.total       (total_q),
		.q_not_empty (q_not_empty),
		.q_word      (q_pop_word),
		.q_pop       (q_pop),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.bin_index   (result.bin_index),
		.peak_level  (result.peak_level),
		.clip_done   (result.clip_done)
	);

endmodule

[rtl/wpb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_checker
// Port-level checks of the peak binner, bound to the top level.
// ----------------------------------------------------------------------------
module wpb_checker
	import wpb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [IDX_W-1:0]  res_bin,
	input logic [PEAK_W-1:0] res_peak,
	input logic              res_done
);

	localparam logic [PEAK_W-1:0] PEAK_MAX = PEAK_W'(32768);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bin)
			&& $stable(res_peak) && $stable(res_done))
		else $error("result word changed while stalled");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_peak <= PEAK_MAX)
		else $error("peak above full scale");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

endmodule

bind waveform_peak_binner_top wpb_checker u_wpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_bin   (result.bin_index),
	.res_peak  (result.peak_level),
	.res_done  (result.clip_done)
);

[tb/wpb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpb_scoreboard
// Watches the configuration, frame and result channels of the peak binner.
// It keeps its own copy of the clip state, works out the (bin, peak, done)
// words that each accepted frame must produce, and compares every accepted
// result word with the oldest one still waiting. It hands the failure count
// and the number of words still due to the testbench top.
// ----------------------------------------------------------------------------
module wpb_scoreboard
	import wpb_pkg::*;
#(
	parameter int BIN_COUNT = 512
) (
	input  logic  clk,
	input  logic  arst_n,
	wpb_cfg_if    cfg,
	wpb_frame_if  frame,
	wpb_result_if result,
	output int    mismatches,
	output int    outstanding
);

	typedef struct packed {
		logic [IDX_W-1:0]  bin;
		logic [PEAK_W-1:0] peak;
		logic              done;
	} bin_peak_t;

	bin_peak_t         peak_due_q[$];
	logic [FRAME_W-1:0] clip_length;
	logic [FRAME_W-1:0] frames_taken;
	longint unsigned   current_bin;
	logic [PEAK_W-1:0] current_peak;
	logic              bin_open;
	int                fail_total;

	function automatic logic [PEAK_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
		return s[SAMPLE_W-1] ? PEAK_W'(17'h10000 - 17'(s[SAMPLE_W-1:0])) : s[SAMPLE_W-1:0];
	endfunction

	function automatic void start_clip();
		frames_taken = '0;
		current_bin  = 0;
		current_peak = '0;
		bin_open     = 1'b0;
	endfunction

	function automatic void take_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		longint unsigned   bin;
		logic [PEAK_W-1:0] la;
		logic [PEAK_W-1:0] ra;
		logic [PEAK_W-1:0] level;
		if (frames_taken >= clip_length)
			return;
		bin   = (64'(frames_taken) * 64'(BIN_COUNT)) / 64'(clip_length);
		la    = magnitude(l);
		ra    = magnitude(r);
		level = (la > ra) ? la : ra;
		if (bin_open && bin != current_bin) begin
			peak_due_q.push_back('{bin: IDX_W'(current_bin), peak: current_peak, done: 1'b0});
			current_peak = '0;
		end
		current_bin = bin;
		if (level > current_peak)
			current_peak = level;
		bin_open = 1'b1;
		frames_taken = frames_taken + 1'b1;
		if (frames_taken == clip_length) begin
			peak_due_q.push_back('{bin: IDX_W'(current_bin), peak: current_peak, done: 1'b1});
			bin_open = 1'b0;
		end
	endfunction

	function automatic void check_word(input bin_peak_t got);
		bin_peak_t want;
		if (peak_due_q.size() == 0) begin
			fail_total++;
			if (fail_total <= 10)
				$display("unexpected result word: bin %0d peak %0d done %0b",
					got.bin, got.peak, got.done);
			return;
		end
		want = peak_due_q.pop_front();
		if (got !== want) begin
			fail_total++;
			if (fail_total <= 10)
				$display("mismatch: expected bin %0d peak %0d done %0b, got bin %0d peak %0d done %0b",
					want.bin, want.peak, want.done, got.bin, got.peak, got.done);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clip_length = TOTAL_RESET;
			start_clip();
			peak_due_q.delete();
			fail_total = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				clip_length = cfg.data;
				start_clip();
			end
			if (frame.valid && frame.ready)
				take_frame(frame.left_sample, frame.right_sample);
			if (result.valid && result.ready)
				check_word('{bin: result.bin_index, peak: result.peak_level,
					done: result.clip_done});
		end
		outstanding <= peak_due_q.size();
		mismatches  <= fail_total;
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the peak binner with clips of stereo frames: a directed opening
// (sample extremes, frames past the clip end, zero and maximum lengths, a
// final frame that closes two bins), then random clips, mostly complete and
// some cut short, under changing sender gaps and receiver stalls, with one
// long receiver hold-off that backs the block up. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import wpb_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int SETTLE      = 64;
	localparam int PHASE_WORDS = 150;
	localparam int HOLD_LEN    = 400;

	logic clk;
	logic arst_n;
	int   idle_pct    = 0;
	int   stall_pct   = 0;
	logic hold_go     = 1'b0;
	logic hold_done   = 1'b0;
	int   hold_cycles = 0;
	int   cycle_count = 0;
	int   mismatches;
	int   outstanding;

	wpb_cfg_if    cfg_ch();
	wpb_frame_if  frame_ch();
	wpb_result_if result_ch();

	waveform_peak_binner_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.frame  (frame_ch),
		.result (result_ch)
	);

	wpb_scoreboard bin_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.frame       (frame_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: long hold-off once, otherwise random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			result_ch.ready <= 1'b0;
			hold_cycles++;
			if (hold_cycles >= HOLD_LEN)
				hold_done <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		while ($urandom_range(0, 99) < idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.left_sample  <= l;
		frame_ch.right_sample <= r;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_total(input logic [FRAME_W-1:0] n);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= n;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// wait out every due word, then the pipeline latency
	task automatic drain();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int counted;
		int clip_len;
		int nframes;

		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.data           = '0;
		frame_ch.valid        = 1'b0;
		frame_ch.left_sample  = '0;
		frame_ch.right_sample = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-frame clip out of reset, then a frame past its end
		send_frame(16'sh8000, 16'sh7FFF);
		send_frame(16'sh1234, -16'sh1234);

		// three frames: every frame a new bin, last one closes two
		drain();
		write_total(FRAME_W'(3));
		send_frame(16'sh7FFF, 16'sh8001);
		send_frame(16'sh0000, 16'sh0000);
		send_frame(-16'sd1, 16'sd1);

		// zero length: all frames dropped
		drain();
		write_total(FRAME_W'(0));
		send_frame(16'sh8000, 16'sh8000);
		send_frame(16'sd5, 16'sd5);

		drain();
		write_total(FRAME_W'(1024));
		send_frame(16'sh7FFF, 16'sh8000);
		send_frame(16'sh8000, 16'sh0000);
		send_frame(16'sh0000, 16'sh7FFF);
		send_frame(16'sd1, -16'sd1);
		send_frame(-16'sd2, 16'sd2);

		// longest clip: everything stays in bin 0
		drain();
		write_total(24'hFFFFFF);
		send_frame(16'sh5555, 16'shAAAA);
		send_frame(16'shAAAA, 16'sh5555);
		send_frame(16'sh0001, 16'shFFFF);

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			counted = 0;
			if (phase == 0) begin
				// every frame its own bin while the result side holds off
				write_total(FRAME_W'(64));
				hold_go = 1'b1;
				for (int i = 0; i < 64; i++)
					send_frame(pick_sample(), pick_sample());
				counted = 64;
				drain();
			end
			while (counted < PHASE_WORDS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						clip_len = $urandom_range(1, 40);
						nframes  = clip_len;
					end
					4, 5: begin
						clip_len = $urandom_range(41, 300);
						nframes  = clip_len;
					end
					6: begin
						clip_len = $urandom_range(512, 513);
						nframes  = $urandom_range(1, 60);
					end
					7: begin
						clip_len = $urandom_range(1, 24'hFFFFFF);
						nframes  = $urandom_range(1, 30);
					end
					8: begin
						clip_len = $urandom_range(1, 8);
						nframes  = clip_len;
					end
					default: begin
						clip_len = $urandom_range(1, 30);
						nframes  = $urandom_range(1, clip_len);
					end
				endcase
				if (nframes == clip_len && $urandom_range(0, 3) == 0)
					nframes += $urandom_range(1, 3);
				write_total(FRAME_W'(clip_len));
				for (int i = 0; i < nframes; i++)
					send_frame(pick_sample(), pick_sample());
				counted += (nframes < clip_len) ? nframes : clip_len;
				drain();
			end
		end

		drain();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/wpb_pkg.sv
rtl/wpb_channels.sv
rtl/wpb_queue.sv
rtl/wpb_front.sv
rtl/wpb_back.sv
rtl/waveform_peak_binner_top.sv
rtl/wpb_checker.sv
tb/wpb_checker.sv
tb/tb_top.sv
